/* hdl/tcag_pkg.sv */
// Package for the text cell attribute generator: register codes, modes, result type.
package tcag_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DISPLAY_MODE  = 3'd0,
        CFG_START_ADDRESS = 3'd1,
        CFG_CURSOR_ADDR   = 3'd2,
        CFG_CURSOR_START  = 3'd3,
        CFG_CURSOR_END    = 3'd4
    } t_cfg_index;

    // Display layouts
    typedef enum logic [1:0] {
        MODE_A_80 = 2'd0,
        MODE_A_40 = 2'd1,
        MODE_B_80 = 2'd2,
        MODE_B_40 = 2'd3
    } t_display_mode;

    localparam logic [7:0]  CTRL_MASK       = 8'h68;
    localparam logic [2:0]  FG_RESET        = 3'd7;
    localparam logic [2:0]  INVERT_MASK     = 3'd7;
    localparam logic [6:0]  CURSOR_START_RST = 7'd31;
    localparam logic [11:0] MODE_A40_BASE   = 12'd1024;
    localparam logic [11:0] MODEL_B_PITCH   = 12'd80;
    localparam logic [3:0]  BAND_ROWS_MUL   = 4'd5;
    localparam int          CFG_DATA_W      = 14;
    localparam int          ADDR_SUM_W      = 15;

    // One result beat
    typedef struct packed {
        logic [10:0] vram_address;
        logic        drawn;
        logic [7:0]  font_index;
        logic [3:0]  font_line;
        logic [2:0]  fg_color;
        logic [2:0]  bg_color;
        logic        solid_line;
    } t_cell_result;

endpackage

/* hdl/text_cell_attribute_generator.sv */
// Text cell attribute generator: address layouts, serial attributes, cursor line.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------------
//  cell in   i_in_valid / o_in_ready      column, row, scan_line, char_code, blink
//  cell out  o_out_valid / i_out_ready    vram_address, drawn, font_index, font_line,
//                                         fg/bg colour, solid_line
//  config    i_cfg_we (no handshake)      i_cfg_index, i_cfg_data
//
//  One cell per cycle while o_in_ready is high; each result is registered.
//  The serial attribute state (colour, graphics set) is updated at each accepted beat.
//  A skid register behind the result register holds one beat so input flows on a stall;
//  o_in_ready drops only while the skid register is full.
//  Synchronous active-low reset clears valids and resets attribute state and configuration.
module text_cell_attribute_generator #(
    parameter int VRAM_DEPTH   = 2048,
    parameter int TEXT_ROWS    = 24,
    parameter int TEXT_COLUMNS = 80,
    parameter int FONT_LINES   = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [tcag_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // cell input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [6:0]  i_column,
    input  logic [4:0]  i_row,
    input  logic [3:0]  i_scan_line,
    input  logic [7:0]  i_char_code,
    input  logic        i_blink_phase,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [10:0] o_vram_address,
    output logic        o_drawn,
    output logic [7:0]  o_font_index,
    output logic [3:0]  o_font_line,
    output logic [2:0]  o_fg_color,
    output logic [2:0]  o_bg_color,
    output logic        o_solid_line
);
    import tcag_pkg::*;

    localparam logic [ADDR_SUM_W-1:0] DEPTH_MASK = ADDR_SUM_W'(VRAM_DEPTH - 1);
    localparam logic [7:0] COLS_FULL = 8'(TEXT_COLUMNS);
    localparam logic [7:0] COLS_HALF = 8'(TEXT_COLUMNS / 2);
    localparam logic [5:0] ROWS_LIM  = 6'(TEXT_ROWS);
    localparam logic [4:0] LINES_LIM = 5'(FONT_LINES);

    // configuration registers
    t_display_mode r_mode;
    logic [13:0]   r_start;
    logic [13:0]   r_cursor;
    logic [6:0]    r_cursor_start;
    logic [4:0]    r_cursor_end;

    // attribute state
    logic          r_gfx, n_gfx;
    logic [2:0]    r_fg, n_fg;

    // output and skid stages
    logic          r_out_vld, n_out_vld;
    logic          r_skid_vld, n_skid_vld;
    t_cell_result  r_out, n_out;
    t_cell_result  r_skid, n_skid;

    logic          w_accept, w_take;
    logic          w_gfx_eff;
    logic [2:0]    w_fg_eff;
    logic [3:0]    w_band5;
    logic [11:0]   w_offset;
    logic [ADDR_SUM_W-1:0] w_sum;
    logic          w_on_screen;
    logic          w_invert;
    logic          w_solid;
    t_cell_result  w_res;

    assign o_in_ready = !r_skid_vld;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_take     = r_out_vld && i_out_ready;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_A_80;
            r_start        <= '0;
            r_cursor       <= '0;
            r_cursor_start <= CURSOR_START_RST;
            r_cursor_end   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DISPLAY_MODE:  r_mode         <= t_display_mode'(i_cfg_data[1:0]);
                CFG_START_ADDRESS: r_start        <= i_cfg_data[13:0];
                CFG_CURSOR_ADDR:   r_cursor       <= i_cfg_data[13:0];
                CFG_CURSOR_START:  r_cursor_start <= i_cfg_data[6:0];
                CFG_CURSOR_END:    r_cursor_end   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // column zero restarts the attributes before the cell uses them
    always_comb begin
        w_gfx_eff = (i_column == 7'd0) ? 1'b0 : r_gfx;
        w_fg_eff  = (i_column == 7'd0) ? FG_RESET : r_fg;
    end

    // cell offset for the selected layout
    always_comb begin
        w_band5 = {2'b00, i_row[4:3]} * BAND_ROWS_MUL;
        case (r_mode)
            MODE_A_80: w_offset = 12'({w_band5, 4'b0}) + 12'({i_row[2:0], 8'b0})
                                  + 12'(i_column);
            MODE_A_40: w_offset = MODE_A40_BASE + 12'({w_band5, 3'b0})
                                  + 12'({i_row[2:0], 7'b0}) + 12'(i_column);
            MODE_B_80: w_offset = 12'(i_row) * MODEL_B_PITCH + 12'(i_column);
            MODE_B_40: w_offset = 12'(i_row) * MODEL_B_PITCH + 12'({i_column, 1'b0});
            default:   w_offset = '0;
        endcase
        w_sum = ADDR_SUM_W'(w_offset) + ADDR_SUM_W'(r_start);
    end

    // build the result beat
    always_comb begin
        w_on_screen = ({1'b0, i_column} < (r_mode[0] ? COLS_HALF : COLS_FULL))
                      && ({1'b0, i_row} < ROWS_LIM);
        w_invert    = i_char_code[7] && (i_blink_phase || r_mode[1]);
        w_solid     = (w_sum == {1'b0, r_cursor})
                      && (i_blink_phase || r_cursor_start[6])
                      && ({1'b0, i_scan_line} < LINES_LIM)
                      && ({1'b0, i_scan_line} >= r_cursor_start[4:0])
                      && ({1'b0, i_scan_line} <= r_cursor_end);
        w_res = '0;
        if (w_on_screen) begin
            w_res.vram_address = 11'(w_sum & DEPTH_MASK);
            w_res.drawn        = 1'b1;
            w_res.font_index   = {w_gfx_eff, i_char_code[6:0]};
            w_res.font_line    = i_scan_line;
            w_res.fg_color     = w_invert ? (w_fg_eff ^ INVERT_MASK) : w_fg_eff;
            w_res.bg_color     = w_invert ? INVERT_MASK : 3'd0;
            w_res.solid_line   = w_solid;
        end
    end

    // next attribute state: control codes load colour and graphics set
    always_comb begin
        n_gfx = r_gfx;
        n_fg  = r_fg;
        if (w_accept) begin
            if ((i_char_code & CTRL_MASK) == 8'd0) begin
                n_gfx = i_char_code[4];
                n_fg  = i_char_code[2:0];
            end else begin
                n_gfx = w_gfx_eff;
                n_fg  = w_fg_eff;
            end
        end
    end

    // advance output register, park a beat in the skid register on a stall
    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (!r_out_vld || w_take) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out      = w_res;
                n_out_vld  = w_accept;
            end
        end else if (w_accept) begin
            n_skid     = w_res;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gfx      <= 1'b0;
            r_fg       <= FG_RESET;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_gfx      <= n_gfx;
            r_fg       <= n_fg;
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_vld;
    assign o_vram_address = r_out.vram_address;
    assign o_drawn        = r_out.drawn;
    assign o_font_index   = r_out.font_index;
    assign o_font_line    = r_out.font_line;
    assign o_fg_color     = r_out.fg_color;
    assign o_bg_color     = r_out.bg_color;
    assign o_solid_line   = r_out.solid_line;

    // skid register is only ever filled behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a beat while output register is empty");

    // a beat accepted during an output stall lands in the skid register
    a_stall_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_out_vld && !i_out_ready) |=> r_skid_vld)
        else $error("beat accepted during stall was not parked");

    // off-screen beats carry all-zero fields
    a_offscreen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.drawn) |-> (r_out.font_index == 8'd0 && r_out.fg_color == 3'd0
        && r_out.solid_line == 1'b0 && r_out.vram_address == 11'd0))
        else $error("undrawn cell has non-zero fields");

    // column zero with a printable code leaves attributes at their reset values
    a_col0_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_column == 7'd0 && (i_char_code & CTRL_MASK) != 8'd0)
        |=> (r_fg == FG_RESET && !r_gfx))
        else $error("column zero did not restart attributes");

endmodule
